FILE: rtl/deq_pkg.sv
// Shared types and codes for the double-ended queue with search.
`default_nettype none
package deq_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned StatW = 2;
  localparam int unsigned DataW = 32;

  localparam logic [OpW-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OpW-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OpW-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OpW-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OpW-1:0] OP_SEARCH     = 3'd4;
  localparam logic [OpW-1:0] OP_DUMP       = 3'd5;
  localparam logic [OpW-1:0] OP_UNUSED_LO  = 3'd6;
  localparam logic [OpW-1:0] OP_UNUSED_HI  = 3'd7;

  localparam logic [StatW-1:0] ST_FOUND     = 2'd0;
  localparam logic [StatW-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StatW-1:0] ST_EMPTY     = 2'd2;
  localparam logic [StatW-1:0] ST_ELEMENT   = 2'd3;

  typedef logic [DataW-1:0] data_t;

  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_SHIFT_R = 2'd1,
    CELL_SHIFT_L = 2'd2
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       load;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/deq_in_if.sv
// Input channel: opcode and value words with a valid/ready handshake.
`default_nettype none
interface deq_in_if;
  logic                                valid;
  logic                                ready;
  logic [deq_pkg::OpW-1:0]             opcode;
  logic signed [deq_pkg::DataW-1:0]    value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface
`default_nettype wire

FILE: rtl/deq_out_if.sv
// Result channel: status, element and last with a valid/ready handshake.
`default_nettype none
interface deq_out_if;
  logic                                valid;
  logic                                ready;
  logic [deq_pkg::StatW-1:0]           status;
  logic signed [deq_pkg::DataW-1:0]    element;
  logic                                last;

  modport source (output valid, output status, output element, output last, input ready);
  modport sink   (input valid, input status, input element, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/deq_cell.sv
// One storage cell of the queue chain, shifting toward either neighbor or loading.
`default_nettype none
module deq_cell (
  input  wire                 clk,
  input  deq_pkg::cell_ctrl_t ctrl,
  input  deq_pkg::data_t      prev_data,
  input  deq_pkg::data_t      next_data,
  input  deq_pkg::data_t      load_data,
  output deq_pkg::data_t      data_o
);
  import deq_pkg::*;

  data_t data_r;

  always_ff @(posedge clk) begin
    case (ctrl.mode)
      CELL_SHIFT_R: data_r <= prev_data;
      CELL_SHIFT_L: data_r <= next_data;
      default: begin
        if (ctrl.load) begin
          data_r <= load_data;
        end
      end
    endcase
  end

  assign data_o = data_r;
endmodule
`default_nettype wire

FILE: rtl/double_ended_queue_with_search_unit.sv
// Double-ended queue of 32-bit values held in a chain of cells, with search and dump.
// The queue sits in a row of DEPTH cells; cell 0 holds the front element outside a rotation.
// Input words (opcode, value) arrive on in_ch and results leave on out_ch, both
// with a valid/ready handshake. Push and pop give no result: push front shifts
// the chain toward the back, pop front shifts it toward the front, push back
// loads the cell at the occupancy count, and pop back only lowers the count.
// Search and dump rotate the whole chain through cell 0 once, one cell per cycle
// while the output register can take each result word that the rotation gives.
// A search result is registered at the last step of the rotation; dump words
// appear one per cycle while the receiver takes them, the front element first. On an empty queue
// search and dump give one empty result at once, valid from the accepting edge on.
// A new input word is taken when no rotation is running and the output register
// is free or being emptied in the same cycle. A stalled receiver holds the
// output register and halts the rotation at a step that has a result to give until the word is taken.
// Reset clears the occupancy and the output valid; cell contents stay as they are.
`default_nettype none
module double_ended_queue_with_search_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  wire        clk,
  input  wire        rst_n,
  deq_in_if.sink     in_ch,
  deq_out_if.source  out_ch
);
  import deq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t           state_r;
  logic [CW-1:0]    count_r;
  logic [AW-1:0]    step_r;
  logic             is_dump_r;
  data_t            key_r;
  logic             found_r;
  logic             out_valid_r;
  logic [StatW-1:0] out_status_r;
  data_t            out_element_r;
  logic             out_last_r;

  data_t      cell_data [DEPTH];
  cell_ctrl_t cell_ctrl [DEPTH];
  cell_mode_t mode;

  logic  out_free, in_fire, full, empty;
  logic  in_range, hit, last_step, emit_need, walk_adv;
  data_t head;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign head      = cell_data[0];

  assign in_range  = (CW'(step_r) < count_r);
  assign hit       = in_range && (head == key_r);
  assign last_step = (step_r == AW'(DEPTH - 1));
  assign emit_need = (state_r == S_WALK) && (is_dump_r ? in_range : last_step);
  assign walk_adv  = (state_r == S_WALK) && (!emit_need || out_free);

  always_comb begin
    mode = CELL_HOLD;
    if (walk_adv) begin
      mode = CELL_SHIFT_L;
    end else if (in_fire) begin
      unique case (in_ch.opcode)
        OP_PUSH_FRONT: if (!full)  mode = CELL_SHIFT_R;
        OP_POP_FRONT:  if (!empty) mode = CELL_SHIFT_L;
        default:       mode = CELL_HOLD;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t prev_d, next_d;
    assign prev_d = (i == 0) ? data_t'(in_ch.value) : cell_data[(i == 0) ? 0 : i - 1];
    assign next_d = cell_data[(i + 1) % DEPTH];
    assign cell_ctrl[i].mode = mode;
    assign cell_ctrl[i].load = in_fire && (in_ch.opcode == OP_PUSH_BACK) && !full
                               && (count_r == CW'(i));
    deq_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .prev_data (prev_d),
      .next_data (next_d),
      .load_data (data_t'(in_ch.value)),
      .data_o    (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_ch.opcode) inside
              OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (!full) count_r <= count_r + CW'(1);
              end
              OP_POP_FRONT, OP_POP_BACK: begin
                if (!empty) count_r <= count_r - CW'(1);
              end
              OP_SEARCH, OP_DUMP: begin
                if (empty) begin
                  out_valid_r <= 1'b1;
                end else begin
                  state_r <= S_WALK;
                end
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          if (walk_adv) begin
            if (emit_need) out_valid_r <= 1'b1;
            if (last_step) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      step_r    <= '0;
      found_r   <= 1'b0;
      key_r     <= data_t'(in_ch.value);
      is_dump_r <= (in_ch.opcode == OP_DUMP);
      out_status_r  <= ST_EMPTY;
      out_element_r <= '0;
      out_last_r    <= 1'b1;
    end else if (walk_adv) begin
      step_r  <= step_r + AW'(1);
      found_r <= found_r || hit;
      if (emit_need) begin
        if (is_dump_r) begin
          out_status_r  <= ST_ELEMENT;
          out_element_r <= head;
          out_last_r    <= (CW'(step_r) + CW'(1) == count_r);
        end else begin
          out_status_r  <= (found_r || hit) ? ST_FOUND : ST_NOT_FOUND;
          out_element_r <= '0;
          out_last_r    <= 1'b1;
        end
      end
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = out_status_r;
  assign out_ch.element = out_element_r;
  assign out_ch.last    = out_last_r;
endmodule
`default_nettype wire

FILE: rtl/deq_checker.sv
// Port-level checker for the double-ended queue, bound to the top level.
`default_nettype none
module deq_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire [deq_pkg::OpW-1:0]     in_opcode,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire [deq_pkg::StatW-1:0]   out_status,
  input wire [deq_pkg::DataW-1:0]   out_element,
  input wire                        out_last
);
  import deq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_element) && $stable(out_last))
    else $error("stalled result word changed");

  a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while a result word is stalled");

  a_walk_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_SEARCH || in_opcode == OP_DUMP)
      |=> !in_ready || out_valid)
    else $error("search or dump neither started a walk nor gave a result");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ELEMENT |-> out_last && out_element == '0)
    else $error("non-element result word malformed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind double_ended_queue_with_search_unit deq_checker u_deq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_opcode   (in_ch.opcode),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_element (out_ch.element),
  .out_last    (out_ch.last)
);
`default_nettype wire

FILE: dv/double_ended_queue_with_search_unit_tb.sv
// Self-checking testbench for the double-ended queue with search, driven over valid/ready words.
`default_nettype none
module double_ended_queue_with_search_unit_tb;
  import deq_pkg::*;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned AW         = $clog2(DEPTH);
  localparam int unsigned ITEMS      = 330;
  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [StatW-1:0] status;
    data_t            element;
    logic             last;
  } result_t;

  logic clk;
  logic rst_n;

  deq_in_if  in_ch ();
  deq_out_if out_ch ();

  double_ended_queue_with_search_unit #(
    .DEPTH (DEPTH)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  data_t       ring_q [DEPTH];
  logic [AW-1:0] ring_head;
  logic [AW:0]   ring_fill;
  result_t     expected_results [$];

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned words_sent;
  int unsigned burst_left;
  int unsigned stall_tick = 0;
  logic [15:0] stall_pattern = 16'hFFFF;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic void predict_results(input logic [OpW-1:0] op, input data_t val);
    logic [AW-1:0] slot;
    logic          hit;
    case (op)
      OP_PUSH_FRONT: begin
        if (ring_fill < DEPTH) begin
          ring_head         = ring_head - 1'b1;
          ring_q[ring_head] = val;
          ring_fill         = ring_fill + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (ring_fill < DEPTH) begin
          slot         = ring_head + ring_fill[AW-1:0];
          ring_q[slot] = val;
          ring_fill    = ring_fill + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (ring_fill != 0) begin
          ring_head = ring_head + 1'b1;
          ring_fill = ring_fill - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (ring_fill != 0) begin
          ring_fill = ring_fill - 1'b1;
        end
      end
      OP_SEARCH: begin
        if (ring_fill == 0) begin
          expected_results.push_back('{ST_EMPTY, '0, 1'b1});
        end else begin
          hit = 1'b0;
          for (int k = 0; k < ring_fill; k++) begin
            slot = ring_head + AW'(k);
            if (ring_q[slot] == val) begin
              hit = 1'b1;
            end
          end
          expected_results.push_back('{hit ? ST_FOUND : ST_NOT_FOUND, '0, 1'b1});
        end
      end
      OP_DUMP: begin
        if (ring_fill == 0) begin
          expected_results.push_back('{ST_EMPTY, '0, 1'b1});
        end else begin
          for (int k = 0; k < ring_fill; k++) begin
            slot = ring_head + AW'(k);
            expected_results.push_back('{ST_ELEMENT, ring_q[slot], k == ring_fill - 1});
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic data_t random_value();
    case ($urandom_range(0, 3))
      0: return data_t'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return data_t'($urandom);
    endcase
  endfunction

  // A key that is stored in the queue when it holds anything, otherwise a random one.
  function automatic data_t stored_key();
    logic [AW-1:0] slot;
    if (ring_fill == 0) begin
      return random_value();
    end
    slot = ring_head + AW'($urandom_range(0, ring_fill - 1));
    return ring_q[slot];
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [OpW-1:0] op, input data_t val);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.value  <= val;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    predict_results(op, val);
    if (op <= OP_DUMP) begin
      words_sent++;
    end
    burst_left--;
    @(negedge clk);
  endtask

  task automatic test_empty_queue();
    send_word(OP_SEARCH, 32'h0000_0000);
    send_word(OP_DUMP, random_value());
    send_word(OP_POP_FRONT, random_value());
    send_word(OP_POP_BACK, random_value());
    send_word(OP_UNUSED_LO, data_t'($urandom));
    send_word(OP_UNUSED_HI, data_t'($urandom));
    send_word(OP_DUMP, 32'hFFFF_FFFF);
  endtask

  task automatic test_value_extremes();
    send_word(OP_PUSH_BACK, 32'h7FFF_FFFF);
    send_word(OP_PUSH_FRONT, 32'h8000_0000);
    send_word(OP_PUSH_BACK, 32'h0000_0000);
    send_word(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_word(OP_SEARCH, 32'h8000_0000);
    send_word(OP_SEARCH, 32'h7FFF_FFFF);
    send_word(OP_SEARCH, 32'h0000_0001);
    send_word(OP_DUMP, 32'h0000_0000);
  endtask

  task automatic test_pop_ends();
    send_word(OP_POP_FRONT, 32'h0000_0000);
    send_word(OP_POP_BACK, 32'h0000_0000);
    send_word(OP_DUMP, 32'h0000_0000);
    send_word(OP_SEARCH, 32'hFFFF_FFFF);
    send_word(OP_POP_BACK, 32'h0000_0000);
    send_word(OP_POP_FRONT, 32'h0000_0000);
    send_word(OP_SEARCH, 32'h0000_0000);
    send_word(OP_DUMP, 32'h0000_0000);
  endtask

  task automatic fill_queue();
    while (ring_fill < DEPTH) begin
      send_word($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, random_value());
    end
    send_word(OP_PUSH_FRONT, random_value());
    send_word(OP_PUSH_BACK, random_value());
    send_word(OP_SEARCH, stored_key());
    send_word(OP_DUMP, random_value());
    send_word(OP_SEARCH, random_value());
  endtask

  task automatic drain_queue();
    while (ring_fill != 0) begin
      send_word($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, random_value());
    end
    send_word($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, random_value());
    send_word(OP_SEARCH, random_value());
    send_word(OP_DUMP, random_value());
  endtask

  task automatic mixed_traffic();
    int unsigned pick;
    repeat (16) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_word(OP_PUSH_FRONT, random_value());
      end else if (pick < 40) begin
        send_word(OP_PUSH_BACK, random_value());
      end else if (pick < 52) begin
        send_word(OP_POP_FRONT, random_value());
      end else if (pick < 64) begin
        send_word(OP_POP_BACK, random_value());
      end else if (pick < 84) begin
        send_word(OP_SEARCH, $urandom_range(0, 1) ? stored_key() : random_value());
      end else if (pick < 94) begin
        send_word(OP_DUMP, random_value());
      end else begin
        send_word($urandom_range(0, 1) ? OP_UNUSED_LO : OP_UNUSED_HI, data_t'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    fill_queue();
    while (words_sent < ITEMS) begin
      case ($urandom_range(0, 5))
        0: fill_queue();
        1: drain_queue();
        default: mixed_traffic();
      endcase
    end
  endtask

  always @(negedge clk) begin
    if (stall_tick[5:0] == 6'd0) begin
      stall_pattern = 16'($urandom) | 16'h0001;
      if ($urandom_range(0, 3) == 0) begin
        stall_pattern = 16'hFFFF;
      end
    end
    out_ch.ready <= stall_pattern[stall_tick[3:0]];
    stall_tick++;
  end

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = '{out_ch.status, out_ch.element, out_ch.last};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: status %0d element %h last %0d",
                   seen.status, seen.element, seen.last);
        end
      end else begin
        want = expected_results.pop_front();
        if (seen.status !== want.status || seen.element !== want.element ||
            seen.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected %0d %h %0d, got %0d %h %0d (status element last)",
                     want.status, want.element, want.last, seen.status, seen.element, seen.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = OP_PUSH_FRONT;
    in_ch.value    = '0;
    ring_head      = '0;
    ring_fill      = '0;
    words_sent     = 0;
    burst_left     = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_queue();
    test_value_extremes();
    test_pop_ends();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (2 * DEPTH) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
